// ===== rtl/lzed_pkg.sv =====
// Shared types and constants of the LZSS entry decompressor.
// Used by the front, the command queue, the back and the top level.
`default_nettype none

package lzed_pkg;

    localparam int unsigned LEN_W       = 24;
    localparam int unsigned POS_W       = 12;
    localparam int unsigned LEFT_W      = 5;
    localparam logic [7:0]  LZ_FLAG     = 8'h20;
    localparam logic [4:0]  MATCH_BIAS  = 5'd2;
    localparam int unsigned CMD_DEPTH   = 2;
    localparam int unsigned CMD_PTR_W   = 1;
    localparam int unsigned CMD_CNT_W   = 2;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_LIT   = 2'd1,
        K_MATCH = 2'd2
    } t_kind;

    // One decoded token: a literal, a ring copy, or nothing but an entry end.
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic [POS_W-1:0]   pos;
        logic [LEFT_W-1:0]  left;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/lzed_in_if.sv =====
// Input channel of the decompressor: one entry byte per beat.
// Depends on nothing.
`default_nettype none

interface lzed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       entry_last;

    modport source (output valid, output in_byte, output entry_last, input ready);
    modport sink (input valid, input in_byte, input entry_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzed_out_if.sv =====
// Output channel of the decompressor: one decoded byte or end marker per beat.
// Depends on nothing.
`default_nettype none

interface lzed_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [23:0] byte_index;
    logic        has_data;
    logic        run_last;
    logic        entry_done;

    modport source (output valid, output out_byte, output byte_index, output has_data,
                    output run_last, output entry_done, input ready);
    modport sink (input valid, input out_byte, input byte_index, input has_data,
                  input run_last, input entry_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzed_front.sv =====
// Front of the decompressor: parses the header and flag groups, turns input beats into
// commands. Depends on lzed_pkg and lzed_in_if.
`default_nettype none

module lzed_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    lzed_in_if.sink         i_in,
    input  wire             i_full,
    output lzed_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        PH_FLAG  = 3'b001,
        PH_TOKEN = 3'b010,
        PH_HIGH  = 3'b100
    } t_phase;

    logic [2:0]                r_hdr_cnt, n_hdr_cnt;
    logic [lzed_pkg::LEN_W-1:0] r_len, n_len;
    logic                      r_comp, n_comp;
    logic [7:0]                r_flags, n_flags;
    logic [3:0]                r_left, n_left;
    t_phase                    r_phase, n_phase;
    logic [7:0]                r_mlow, n_mlow;

    logic                      accept;
    logic [7:0]                nt_flags;
    logic [3:0]                nt_left;
    t_phase                    nt_phase;
    lzed_pkg::t_cmd            cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    assign nt_flags = r_flags >> 1;
    assign nt_left  = (r_left == 4'd0) ? 4'd0 : r_left - 4'd1;
    assign nt_phase = (nt_left != 4'd0) ? PH_TOKEN : PH_FLAG;

    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_len     = r_len;
        n_comp    = r_comp;
        n_flags   = r_flags;
        n_left    = r_left;
        n_phase   = r_phase;
        n_mlow    = r_mlow;
        cmd       = '0;
        cmd.kind  = lzed_pkg::K_NONE;
        cmd.data  = i_in.in_byte;
        cmd.len   = r_len;
        cmd.last  = i_in.entry_last;
        if (accept) begin
            if (r_hdr_cnt < 3'd4) begin
                unique case (r_hdr_cnt[1:0])
                    2'd0: n_len[7:0]   = i_in.in_byte;
                    2'd1: n_len[15:8]  = i_in.in_byte;
                    2'd2: n_len[23:16] = i_in.in_byte;
                    default: begin
                        n_comp  = (i_in.in_byte == lzed_pkg::LZ_FLAG);
                        n_phase = PH_FLAG;
                    end
                endcase
                n_hdr_cnt = r_hdr_cnt + 3'd1;
            end else if (!r_comp) begin
                cmd.kind = lzed_pkg::K_LIT;
            end else begin
                unique case (r_phase)
                    PH_FLAG: begin
                        n_flags = i_in.in_byte;
                        n_left  = 4'd8;
                        n_phase = PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        if (r_flags[0]) begin
                            cmd.kind = lzed_pkg::K_LIT;
                            n_flags  = nt_flags;
                            n_left   = nt_left;
                            n_phase  = nt_phase;
                        end else begin
                            n_mlow  = i_in.in_byte;
                            n_phase = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        cmd.kind = lzed_pkg::K_MATCH;
                        cmd.pos  = {i_in.in_byte[3:0], r_mlow};
                        cmd.left = {1'b0, i_in.in_byte[7:4]} + lzed_pkg::MATCH_BIAS;
                        n_flags  = nt_flags;
                        n_left   = nt_left;
                        n_phase  = nt_phase;
                    end
                    default: begin
                        n_phase = PH_FLAG;
                    end
                endcase
            end
            if (i_in.entry_last) begin
                n_hdr_cnt = 3'd0;
                n_len     = '0;
                n_comp    = 1'b0;
                n_flags   = 8'd0;
                n_left    = 4'd0;
                n_phase   = PH_FLAG;
                n_mlow    = 8'd0;
            end
        end
    end

    assign o_push.valid = accept && ((cmd.kind != lzed_pkg::K_NONE) || i_in.entry_last);
    assign o_push.cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= 3'd0;
            r_len     <= '0;
            r_comp    <= 1'b0;
            r_flags   <= 8'd0;
            r_left    <= 4'd0;
            r_phase   <= PH_FLAG;
            r_mlow    <= 8'd0;
        end else begin
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_comp    <= n_comp;
            r_flags   <= n_flags;
            r_left    <= n_left;
            r_phase   <= n_phase;
            r_mlow    <= n_mlow;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzed_cmd_fifo.sv =====
// Short command queue between the front and the back of the decompressor.
// Depends on lzed_pkg.
`default_nettype none

module lzed_cmd_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  lzed_pkg::t_push     i_push,
    output logic                o_full,
    output lzed_pkg::t_push     o_head,
    input  wire                 i_pop
);

    lzed_pkg::t_cmd                      r_mem [lzed_pkg::CMD_DEPTH];
    logic [lzed_pkg::CMD_PTR_W-1:0]      r_wptr, n_wptr;
    logic [lzed_pkg::CMD_PTR_W-1:0]      r_rptr, n_rptr;
    logic [lzed_pkg::CMD_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                do_push;
    logic                                do_pop;

    assign o_full       = (r_cnt == lzed_pkg::CMD_CNT_W'(lzed_pkg::CMD_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzed_back.sv =====
// Back of the decompressor: carries out literal and copy commands through the history
// ring and drives the output register. Depends on lzed_pkg and lzed_out_if.
`default_nettype none

module lzed_back #(
    parameter int unsigned WINDOW_SIZE = 4096
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  lzed_pkg::t_push i_head,
    output logic            o_pop,
    lzed_out_if.source      o_out
);

    localparam int unsigned AW = $clog2(WINDOW_SIZE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_MARK = 4'b1000
    } t_state;

    logic [7:0]                  r_ring [WINDOW_SIZE];
    logic [7:0]                  r_rdata;
    logic                        r_rvalid;

    t_state                      r_state, n_state;
    lzed_pkg::t_kind             r_kind, n_kind;
    logic [7:0]                  r_data, n_data;
    logic [AW-1:0]               r_pos, n_pos;
    logic [lzed_pkg::LEFT_W-1:0] r_left, n_left;
    logic [lzed_pkg::LEN_W-1:0]  r_len, n_len;
    logic                        r_last, n_last;
    logic                        r_any, n_any;
    logic [lzed_pkg::LEN_W-1:0]  r_emitted, n_emitted;
    logic [AW-1:0]               r_wpos, n_wpos;
    logic [AW:0]                 r_fill, n_fill;

    logic                        r_ov, n_ov;
    logic [7:0]                  r_obyte, n_obyte;
    logic [lzed_pkg::LEN_W-1:0]  r_oidx, n_oidx;
    logic                        r_odata, n_odata;
    logic                        r_orun, n_orun;
    logic                        r_odone, n_odone;

    logic                        slot_free;
    logic                        emit_ok;
    logic                        run_end;
    logic [7:0]                  wdata;
    logic                        ring_we;
    logic                        rd_en;

    assign slot_free = !r_ov || o_out.ready;
    assign emit_ok   = (r_emitted < r_len);
    assign run_end   = (r_left == '0) || ((r_emitted + 24'd1) == r_len);
    assign wdata     = (r_kind == lzed_pkg::K_MATCH) ? (r_rvalid ? r_rdata : 8'd0) : r_data;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_data    = r_data;
        n_pos     = r_pos;
        n_left    = r_left;
        n_len     = r_len;
        n_last    = r_last;
        n_any     = r_any;
        n_emitted = r_emitted;
        n_wpos    = r_wpos;
        n_fill    = r_fill;
        n_ov      = r_ov && !o_out.ready;
        n_obyte   = r_obyte;
        n_oidx    = r_oidx;
        n_odata   = r_odata;
        n_orun    = r_orun;
        n_odone   = r_odone;
        o_pop     = 1'b0;
        ring_we   = 1'b0;
        rd_en     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_kind = i_head.cmd.kind;
                    n_data = i_head.cmd.data;
                    n_pos  = i_head.cmd.pos[AW-1:0];
                    n_left = i_head.cmd.left;
                    n_len  = i_head.cmd.len;
                    n_last = i_head.cmd.last;
                    n_any  = 1'b0;
                    unique case (i_head.cmd.kind)
                        lzed_pkg::K_LIT:   n_state = S_WR;
                        lzed_pkg::K_MATCH: n_state = S_RD;
                        default:           n_state = S_MARK;
                    endcase
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                if (!emit_ok || slot_free) begin
                    ring_we = 1'b1;
                    n_wpos  = r_wpos + 1'b1;
                    n_fill  = r_fill[AW] ? r_fill : r_fill + 1'b1;
                    n_pos   = r_pos + 1'b1;
                    if (emit_ok) begin
                        n_ov      = 1'b1;
                        n_obyte   = wdata;
                        n_oidx    = r_emitted;
                        n_odata   = 1'b1;
                        n_orun    = run_end;
                        n_odone   = run_end && r_last;
                        n_emitted = r_emitted + 24'd1;
                        n_any     = 1'b1;
                    end
                    if (r_left != '0) begin
                        n_left  = r_left - 1'b1;
                        n_state = S_RD;
                    end else if (r_last && !(r_any || emit_ok)) begin
                        n_state = S_MARK;
                    end else begin
                        n_state = S_IDLE;
                        if (r_last) begin
                            n_emitted = '0;
                            n_wpos    = '0;
                            n_fill    = '0;
                        end
                    end
                end
            end
            S_MARK: begin
                if (slot_free) begin
                    n_ov      = 1'b1;
                    n_obyte   = 8'd0;
                    n_oidx    = r_emitted;
                    n_odata   = 1'b0;
                    n_orun    = 1'b1;
                    n_odone   = 1'b1;
                    n_emitted = '0;
                    n_wpos    = '0;
                    n_fill    = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ring positions at or above the fill count were not written in this entry and read as zero.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wpos] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata  <= r_ring[r_pos];
            r_rvalid <= ({1'b0, r_pos} < r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_pos   <= n_pos;
        r_left  <= n_left;
        r_len   <= n_len;
        r_last  <= n_last;
        r_any   <= n_any;
        r_obyte <= n_obyte;
        r_oidx  <= n_oidx;
        r_odata <= n_odata;
        r_orun  <= n_orun;
        r_odone <= n_odone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_emitted <= '0;
            r_wpos    <= '0;
            r_fill    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_emitted <= n_emitted;
            r_wpos    <= n_wpos;
            r_fill    <= n_fill;
            r_ov      <= n_ov;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_obyte;
    assign o_out.byte_index = r_oidx;
    assign o_out.has_data   = r_odata;
    assign o_out.run_last   = r_orun;
    assign o_out.entry_done = r_odone;

endmodule

`default_nettype wire

// ===== rtl/lzss_entry_decompressor_unit.sv =====
// Header, flag, and match-low beats stay in the front and cause no back work unless they
// carry the entry's last flag. The back pops a literal in idle and writes it; a copy runs a
// ring read and a ring write per byte. A result passes the command queue, the back's command
// registers and the output register; an output stall holds the back, which takes no new command until done.
// Reset is synchronous and clears control state; the ring is not cleared, a fill count
// masks unwritten positions of the current entry, so no clearing pass is needed.
`default_nettype none

module lzss_entry_decompressor_unit #(
    parameter int unsigned WINDOW_SIZE = 4096
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lzed_in_if.sink    i_in,
    lzed_out_if.source o_out
);

    lzed_pkg::t_push push;
    lzed_pkg::t_push head;
    logic            full;
    logic            pop;

    lzed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    lzed_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    lzed_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
